// ===== sv/ffpa_pkg.sv =====
// Package for the first-fit page extent allocator: widths, codes and state types.
// Used by ffpa_alu and first_fit_page_extent_allocator_top; depends on nothing.
package ffpa_pkg;

    localparam int ADDR_W          = 52;
    localparam int PAGE_W          = 40;
    localparam int BYTES_W         = 52;
    localparam int PAGE_SHIFT      = 12;
    localparam int MAX_EXTENTS_DEF = 64;

    localparam logic [ADDR_W-1:0] MIN_BASE    = ADDR_W'(64'h1000);
    localparam logic [ADDR_W-1:0] ROUND_ADDEND = ADDR_W'(64'hfff);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_INIT  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ROUND,
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND,
        S_FIND,
        S_APPEND_A,
        S_APPEND_B,
        S_WALK_RD,
        S_WALK_CHK,
        S_TAKE,
        S_UNLINK,
        S_RESP
    } fsm_t;

endpackage

// ===== sv/ffpa_alu.sv =====
// Shared 52-bit adder of the allocator: base rounding, fit compare and address sum.
// Depends on ffpa_pkg.
module ffpa_alu
(
    input  ffpa_pkg::alu_op_t                 op,
    input  logic [ffpa_pkg::ADDR_W-1:0]      x,
    input  logic [ffpa_pkg::PAGE_W-1:0]      y,
    output logic [ffpa_pkg::ADDR_W-1:0]      sum
);

    logic [ffpa_pkg::ADDR_W-1:0] a;
    logic [ffpa_pkg::ADDR_W-1:0] b;
    logic                         cin;

    // Subtraction is done as x + ~y + 1, so the top bit of the sum flags a borrow.
    always_comb
    begin
        a   = x;
        b   = {{(ffpa_pkg::ADDR_W-ffpa_pkg::PAGE_W){1'b0}}, y};
        cin = 1'b0;
        unique case (op)
            ffpa_pkg::ALU_ROUND:
            begin
                a = (x < ffpa_pkg::MIN_BASE) ? ffpa_pkg::MIN_BASE : x;
                b = ffpa_pkg::ROUND_ADDEND;
            end
            ffpa_pkg::ALU_SUB:
            begin
                b   = ~{{(ffpa_pkg::ADDR_W-ffpa_pkg::PAGE_W){1'b0}}, y};
                cin = 1'b1;
            end
            default:
            begin
                cin = 1'b0;
            end
        endcase
    end

    assign sum = a + b + {{(ffpa_pkg::ADDR_W-1){1'b0}}, cin};

endmodule

// ===== sv/first_fit_page_extent_allocator_top.sv =====
// Top level of the first-fit page extent allocator: sequencer, extent tables and result register.
// Depends on ffpa_pkg and ffpa_alu.
//
//  Channel  Direction  Handshake             Payload
//  in       to block   in_valid / in_stall   action, phys_address, region_bytes, page_count
//  out      from block out_valid / out_stall block_address, status
//
// One word is worked on at a time; in_stall is high from acceptance until the sequencer is idle.
// An add and a free each scan the slots one per cycle to find the lowest free slot (up to
// MAX_EXTENTS); a full table ends the scan with status full.
// An allocation reads and then checks each extent visited on the walk from the head, and
// takes pages when one fits. An allocation that finds the list never loaded or empty, and
// an unknown action, go straight to the response.
// The result sits in an output register; the sequencer waits in its last state while a
// previous result is still stalled. Reset is asynchronous and empties the list at once.
module first_fit_page_extent_allocator_top
#(
    parameter int MAX_EXTENTS = ffpa_pkg::MAX_EXTENTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic [ffpa_pkg::ADDR_W-1:0]      phys_address,
    input  logic [ffpa_pkg::BYTES_W-1:0]     region_bytes,
    input  logic [ffpa_pkg::PAGE_W-1:0]      page_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ffpa_pkg::ADDR_W-1:0]      block_address,
    output logic [1:0]                        status
);

    // Slot index width, and link width that can also hold the null value MAX_EXTENTS.
    localparam int IDX_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int LINK_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_EXTENTS);
    localparam logic [LINK_W-1:0] LAST_STEP = LINK_W'(MAX_EXTENTS - 1);

    // Extent tables, one entry per slot.
    logic [ffpa_pkg::PAGE_W-1:0] start_mem [MAX_EXTENTS];
    logic [ffpa_pkg::PAGE_W-1:0] pages_mem [MAX_EXTENTS];
    logic [LINK_W-1:0]           next_mem  [MAX_EXTENTS];
    logic [LINK_W-1:0]           prev_mem  [MAX_EXTENTS];

    logic [ffpa_pkg::PAGE_W-1:0] start_rd_reg;
    logic [ffpa_pkg::PAGE_W-1:0] pages_rd_reg;
    logic [LINK_W-1:0]           next_rd_reg;
    logic [LINK_W-1:0]           prev_rd_reg;

    ffpa_pkg::fsm_t              state_reg, state_next;
    logic [MAX_EXTENTS-1:0]      in_use_reg, in_use_next;
    logic [LINK_W-1:0]           head_reg, head_next;
    logic [LINK_W-1:0]           tail_reg, tail_next;
    logic                        ever_reg, ever_next;

    logic [1:0]                  act_reg, act_next;
    logic [ffpa_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ffpa_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [ffpa_pkg::PAGE_W-1:0] count_reg, count_next;

    logic [LINK_W-1:0]           cur_reg, cur_next;
    logic [LINK_W-1:0]           steps_reg, steps_next;
    logic [LINK_W-1:0]           scan_reg, scan_next;
    logic [ffpa_pkg::PAGE_W-1:0] new_page_reg, new_page_next;
    logic [ffpa_pkg::PAGE_W-1:0] new_pages_reg, new_pages_next;
    logic [ffpa_pkg::PAGE_W-1:0] rem_reg, rem_next;

    logic [ffpa_pkg::ADDR_W-1:0] res_block_reg, res_block_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ffpa_pkg::ADDR_W-1:0] out_block_reg, out_block_next;
    logic [1:0]                  out_status_reg, out_status_next;

    ffpa_pkg::alu_op_t           alu_op;
    logic [ffpa_pkg::ADDR_W-1:0] alu_x;
    logic [ffpa_pkg::PAGE_W-1:0] alu_y;
    logic [ffpa_pkg::ADDR_W-1:0] alu_sum;

    logic                        accept;
    logic                        out_free;
    logic                        fits;
    logic                        slot_free;
    logic [IDX_W-1:0]            cur_idx;
    logic [IDX_W-1:0]            scan_idx;
    logic [LINK_W-1:0]           steps_inc;

    // Write ports, one per table.
    logic                        start_we, pages_we, next_we, prev_we;
    logic [IDX_W-1:0]            start_wa, pages_wa, next_wa, prev_wa;
    logic [ffpa_pkg::PAGE_W-1:0] start_wd, pages_wd;
    logic [LINK_W-1:0]           next_wd, prev_wd;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ffpa_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_idx   = cur_reg[IDX_W-1:0];
    assign scan_idx  = scan_reg[IDX_W-1:0];
    assign slot_free = !in_use_reg[scan_idx];
    assign steps_inc = steps_reg + LINK_W'(1);
    // The subtraction borrows when the extent is smaller than the request.
    assign fits      = !alu_sum[ffpa_pkg::ADDR_W-1];

    ffpa_alu u_alu
    (
        .op  (alu_op),
        .x   (alu_x),
        .y   (alu_y),
        .sum (alu_sum)
    );

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_op = ffpa_pkg::ALU_ADD;
        alu_x  = {{(ffpa_pkg::ADDR_W-ffpa_pkg::PAGE_W){1'b0}}, start_rd_reg};
        alu_y  = rem_reg;
        unique case (state_reg)
            ffpa_pkg::S_ROUND:
            begin
                alu_op = ffpa_pkg::ALU_ROUND;
                alu_x  = addr_reg;
            end
            ffpa_pkg::S_WALK_CHK:
            begin
                alu_op = ffpa_pkg::ALU_SUB;
                alu_x  = {{(ffpa_pkg::ADDR_W-ffpa_pkg::PAGE_W){1'b0}}, pages_rd_reg};
                alu_y  = count_reg;
            end
            default:
            begin
                alu_op = ffpa_pkg::ALU_ADD;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ffpa_pkg::ACT_ADD:   state_next = ffpa_pkg::S_ROUND;
                        ffpa_pkg::ACT_FREE:  state_next = ffpa_pkg::S_FIND;
                        ffpa_pkg::ACT_ALLOC:
                        begin
                            if (ever_reg && head_reg != NULL_LINK)
                                state_next = ffpa_pkg::S_WALK_RD;
                            else
                                state_next = ffpa_pkg::S_RESP;
                        end
                        default:             state_next = ffpa_pkg::S_RESP;
                    endcase
                end
            end
            ffpa_pkg::S_ROUND:    state_next = ffpa_pkg::S_FIND;
            ffpa_pkg::S_FIND:
            begin
                if (scan_reg == NULL_LINK)
                    state_next = ffpa_pkg::S_RESP;
                else if (slot_free)
                    state_next = ffpa_pkg::S_APPEND_A;
            end
            ffpa_pkg::S_APPEND_A: state_next = ffpa_pkg::S_APPEND_B;
            ffpa_pkg::S_APPEND_B: state_next = ffpa_pkg::S_RESP;
            ffpa_pkg::S_WALK_RD:  state_next = ffpa_pkg::S_WALK_CHK;
            ffpa_pkg::S_WALK_CHK:
            begin
                if (fits)
                    state_next = in_use_reg[cur_idx] ? ffpa_pkg::S_TAKE : ffpa_pkg::S_RESP;
                else if (next_rd_reg == NULL_LINK || steps_reg == LAST_STEP)
                    state_next = ffpa_pkg::S_RESP;
                else
                    state_next = ffpa_pkg::S_WALK_RD;
            end
            ffpa_pkg::S_TAKE:
            begin
                state_next = (rem_reg == '0) ? ffpa_pkg::S_UNLINK : ffpa_pkg::S_RESP;
            end
            ffpa_pkg::S_UNLINK:   state_next = ffpa_pkg::S_RESP;
            ffpa_pkg::S_RESP:
            begin
                if (out_free)
                    state_next = ffpa_pkg::S_IDLE;
            end
            default:              state_next = ffpa_pkg::S_IDLE;
        endcase
    end

    // Datapath, list control and table writes.
    always_comb
    begin
        in_use_next     = in_use_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        ever_next       = ever_reg;
        act_next        = act_reg;
        addr_next       = addr_reg;
        bytes_next      = bytes_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        scan_next       = scan_reg;
        new_page_next   = new_page_reg;
        new_pages_next  = new_pages_reg;
        rem_next        = rem_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_block_next  = out_block_reg;
        out_status_next = out_status_reg;

        start_we = 1'b0;
        pages_we = 1'b0;
        next_we  = 1'b0;
        prev_we  = 1'b0;
        start_wa = scan_idx;
        pages_wa = scan_idx;
        next_wa  = scan_idx;
        prev_wa  = scan_idx;
        start_wd = new_page_reg;
        pages_wd = new_pages_reg;
        next_wd  = NULL_LINK;
        prev_wd  = tail_reg;

        unique case (state_reg)
            ffpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    act_next        = action;
                    addr_next       = phys_address;
                    bytes_next      = region_bytes;
                    count_next      = page_count;
                    cur_next        = head_reg;
                    steps_next      = '0;
                    scan_next       = '0;
                    new_page_next   = phys_address[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
                    new_pages_next  = page_count;
                    res_block_next  = '0;
                    res_status_next = ffpa_pkg::ST_OK;
                    if (action == ffpa_pkg::ACT_ALLOC)
                        res_status_next = ever_reg ? ffpa_pkg::ST_NO_SPACE
                                                   : ffpa_pkg::ST_NO_INIT;
                end
            end
            ffpa_pkg::S_ROUND:
            begin
                new_page_next  = alu_sum[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
                new_pages_next = bytes_reg[ffpa_pkg::BYTES_W-1:ffpa_pkg::PAGE_SHIFT];
            end
            ffpa_pkg::S_FIND:
            begin
                if (scan_reg == NULL_LINK)
                    res_status_next = ffpa_pkg::ST_FULL;
                else if (!slot_free)
                    scan_next = scan_reg + LINK_W'(1);
            end
            ffpa_pkg::S_APPEND_A:
            begin
                start_we              = 1'b1;
                pages_we              = 1'b1;
                next_we               = 1'b1;
                prev_we               = 1'b1;
                in_use_next[scan_idx] = 1'b1;
            end
            ffpa_pkg::S_APPEND_B:
            begin
                if (tail_reg != NULL_LINK)
                begin
                    next_we = 1'b1;
                    next_wa = tail_reg[IDX_W-1:0];
                    next_wd = scan_reg;
                end
                if (head_reg == NULL_LINK)
                    head_next = scan_reg;
                tail_next       = scan_reg;
                ever_next       = 1'b1;
                res_status_next = ffpa_pkg::ST_OK;
            end
            ffpa_pkg::S_WALK_CHK:
            begin
                if (fits)
                begin
                    rem_next = alu_sum[ffpa_pkg::PAGE_W-1:0];
                    if (in_use_reg[cur_idx])
                        res_status_next = ffpa_pkg::ST_OK;
                end
                else
                begin
                    cur_next   = next_rd_reg;
                    steps_next = steps_inc;
                end
            end
            ffpa_pkg::S_TAKE:
            begin
                pages_we       = 1'b1;
                pages_wa       = cur_idx;
                pages_wd       = rem_reg;
                res_block_next = {alu_sum[ffpa_pkg::PAGE_W-1:0],
                                  {ffpa_pkg::PAGE_SHIFT{1'b0}}};
            end
            ffpa_pkg::S_UNLINK:
            begin
                if (next_rd_reg != NULL_LINK)
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd_reg[IDX_W-1:0];
                    prev_wd = prev_rd_reg;
                end
                if (prev_rd_reg != NULL_LINK)
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd_reg[IDX_W-1:0];
                    next_wd = next_rd_reg;
                end
                if (head_reg == cur_reg)
                    head_next = next_rd_reg;
                if (tail_reg == cur_reg)
                    tail_next = prev_rd_reg;
                in_use_next[cur_idx] = 1'b0;
            end
            ffpa_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = res_block_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    // Tables: one write port and one registered read port each, read at the walk cursor.
    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[start_wa] <= start_wd;
        if (pages_we)
            pages_mem[pages_wa] <= pages_wd;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        start_rd_reg <= start_mem[cur_idx];
        pages_rd_reg <= pages_mem[cur_idx];
        next_rd_reg  <= next_mem[cur_idx];
        prev_rd_reg  <= prev_mem[cur_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffpa_pkg::S_IDLE;
            in_use_reg    <= '0;
            head_reg      <= NULL_LINK;
            tail_reg      <= NULL_LINK;
            ever_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            ever_reg      <= ever_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        addr_reg       <= addr_next;
        bytes_reg      <= bytes_next;
        count_reg      <= count_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        scan_reg       <= scan_next;
        new_page_reg   <= new_page_next;
        new_pages_reg  <= new_pages_next;
        rem_reg        <= rem_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        out_block_reg  <= out_block_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid     = out_valid_reg;
    assign block_address = out_block_reg;
    assign status        = out_status_reg;

`ifndef SYNTH
    // The head and the tail are null together.
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) == (tail_reg == NULL_LINK))
        else $error("list head and tail disagree on emptiness");

    // Once an extent was added the allocator stays initialized.
    a_ever_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ever_reg))
        else $error("initialized flag cleared");

    // A not-initialized answer is only formed while nothing was ever added.
    a_no_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffpa_pkg::S_RESP && res_status_reg == ffpa_pkg::ST_NO_INIT)
        |-> !ever_reg)
        else $error("not-initialized status after an add");

    // A nonzero address is only returned with status ok.
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_block_reg != '0) |-> (out_status_reg == ffpa_pkg::ST_OK))
        else $error("address returned with an error status");

    // The walk only runs on an allocation.
    a_walk_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffpa_pkg::S_WALK_RD) |-> (act_reg == ffpa_pkg::ACT_ALLOC))
        else $error("list walk outside an allocation");
`endif

endmodule
